/* hw/rtl/e2c_pkg.sv */
// Shared types, constants and helper functions for the epoch-to-calendar block.
// Depends on nothing; used by e2c_ctrl, e2c_datapath and epoch_seconds_to_calendar.

package e2c_pkg;

  // Input and result field widths
  localparam int SecondsW = 32;
  localparam int YearW    = 12;
  localparam int MonthW   = 4;
  localparam int DayW     = 5;
  localparam int HourW    = 5;
  localparam int MinuteW  = 6;
  localparam int SecondW  = 6;
  localparam int WeekdayW = 3;

  // Quotient register: the day count is the widest quotient (below 2^16)
  localparam int QuoW = 16;

  // Reciprocals for the constant divisions, each exact over its dividend range:
  //   days = ((t >> 7) * DayRecip) >> 35            (t / 86400, t >> 7 below 2^25)
  //   hour = ((sod >> 4) * HourRecip) >> 21         (sod / 3600, sod >> 4 below 5400)
  //   min  = ((rem >> 2) * MinRecip) >> 14          (rem / 60, rem >> 2 below 900)
  //   week = ((days + 4) * WdayRecip) >> 19         ((days + 4) / 7, below 2^16)
  localparam logic [25:0] DayRecip  = 26'd50903317;
  localparam logic [13:0] HourRecip = 14'd9321;
  localparam logic [10:0] MinRecip  = 11'd1093;
  localparam logic [16:0] WdayRecip = 17'd74899;

  // Epoch: 1970-01-01 was a Thursday
  localparam logic [YearW-1:0] EpochYear    = 12'd1970;
  localparam logic [6:0]       EpochCent    = 7'd70;    // 1970 mod 100
  localparam logic [8:0]       EpochQuad    = 9'd370;   // 1970 mod 400
  localparam logic [6:0]       CentLast     = 7'd99;
  localparam logic [8:0]       QuadLast     = 9'd399;
  localparam logic [SecondsW-1:0] WeekdayBias = 32'd4;
  localparam logic [MonthW-1:0] LastMonth   = 4'd11;    // zero-based December

  typedef enum logic [2:0] {
    S_IDLE,
    S_DAY,
    S_HOUR,
    S_MIN,
    S_WDAY,
    S_YEAR,
    S_MONTH,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_QUO,
    OP_REM,
    OP_YEAR,
    OP_MONTH
  } op_t;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN,
    DIV_WDAY
  } divsel_t;

  typedef struct packed {
    op_t     op;
    divsel_t sel;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } status_t;

  function automatic logic [16:0] divisor_of(input divsel_t sel);
    logic [16:0] d;
    unique case (sel)
      DIV_DAY:  d = 17'd86400;
      DIV_HOUR: d = 17'd3600;
      DIV_MIN:  d = 17'd60;
      DIV_WDAY: d = 17'd7;
      default:  d = 17'd7;
    endcase
    return d;
  endfunction

  // Days in zero-based month; February follows the leap flag
  function automatic logic [4:0] month_len(input logic leap, input logic [MonthW-1:0] mon);
    logic [4:0] len;
    unique case (mon)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3,
      4'd5,
      4'd8,
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* hw/rtl/e2c_ctrl.sv */
// Controller FSM for the epoch-to-calendar block: sequences divisions, year and month loops.
// Depends on e2c_pkg.

module e2c_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  e2c_pkg::status_t   status,
  output e2c_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               done
);

  e2c_pkg::state_t                state;
  e2c_pkg::state_t                state_next;
  logic                           phase;
  logic                           phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= e2c_pkg::S_IDLE;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // Next state; each division takes a quotient phase and a remainder phase
  always_comb begin
    state_next = state;
    phase_next = 1'b0;
    unique case (state)
      e2c_pkg::S_IDLE: begin
        if (start) state_next = e2c_pkg::S_DAY;
      end
      e2c_pkg::S_DAY: begin
        if (phase) state_next = e2c_pkg::S_HOUR;
        else       phase_next = 1'b1;
      end
      e2c_pkg::S_HOUR: begin
        if (phase) state_next = e2c_pkg::S_MIN;
        else       phase_next = 1'b1;
      end
      e2c_pkg::S_MIN: begin
        if (phase) state_next = e2c_pkg::S_WDAY;
        else       phase_next = 1'b1;
      end
      e2c_pkg::S_WDAY: begin
        if (phase) state_next = e2c_pkg::S_YEAR;
        else       phase_next = 1'b1;
      end
      e2c_pkg::S_YEAR: begin
        if (status.year_done) state_next = e2c_pkg::S_MONTH;
      end
      e2c_pkg::S_MONTH: begin
        if (status.month_done) state_next = e2c_pkg::S_DONE;
      end
      e2c_pkg::S_DONE: state_next = e2c_pkg::S_IDLE;
      default:         state_next = e2c_pkg::S_IDLE;
    endcase
  end

  // Commands and handshake outputs
  always_comb begin
    cmd.op  = e2c_pkg::OP_NONE;
    cmd.sel = e2c_pkg::DIV_DAY;
    busy    = (state != e2c_pkg::S_IDLE);
    done    = 1'b0;
    unique case (state)
      e2c_pkg::S_IDLE: begin
        if (start) cmd.op = e2c_pkg::OP_LOAD;
      end
      e2c_pkg::S_DAY: begin
        cmd.op  = phase ? e2c_pkg::OP_REM : e2c_pkg::OP_QUO;
        cmd.sel = e2c_pkg::DIV_DAY;
      end
      e2c_pkg::S_HOUR: begin
        cmd.op  = phase ? e2c_pkg::OP_REM : e2c_pkg::OP_QUO;
        cmd.sel = e2c_pkg::DIV_HOUR;
      end
      e2c_pkg::S_MIN: begin
        cmd.op  = phase ? e2c_pkg::OP_REM : e2c_pkg::OP_QUO;
        cmd.sel = e2c_pkg::DIV_MIN;
      end
      e2c_pkg::S_WDAY: begin
        cmd.op  = phase ? e2c_pkg::OP_REM : e2c_pkg::OP_QUO;
        cmd.sel = e2c_pkg::DIV_WDAY;
      end
      e2c_pkg::S_YEAR: begin
        if (!status.year_done) cmd.op = e2c_pkg::OP_YEAR;
      end
      e2c_pkg::S_MONTH: begin
        if (!status.month_done) cmd.op = e2c_pkg::OP_MONTH;
      end
      e2c_pkg::S_DONE: done = 1'b1;
      default: ;
    endcase
  end

endmodule

/* hw/rtl/e2c_datapath.sv */
// Datapath for the epoch-to-calendar block: reciprocal-multiply divisions by constants,
// year and month subtract loops. Depends on e2c_pkg; driven by commands from e2c_ctrl.

module e2c_datapath (
  input  logic                            clk,
  input  logic [e2c_pkg::SecondsW-1:0]    unix_seconds,
  input  e2c_pkg::cmd_t                   cmd,
  output e2c_pkg::status_t                status,
  output logic [e2c_pkg::YearW-1:0]       year,
  output logic [e2c_pkg::MonthW-1:0]      month,
  output logic [e2c_pkg::DayW-1:0]        day_of_month,
  output logic [e2c_pkg::HourW-1:0]       hour,
  output logic [e2c_pkg::MinuteW-1:0]     minute,
  output logic [e2c_pkg::SecondW-1:0]     second,
  output logic [e2c_pkg::WeekdayW-1:0]    weekday
);

  logic [e2c_pkg::SecondsW-1:0] acc;
  logic [e2c_pkg::QuoW-1:0]     quo;
  logic [e2c_pkg::QuoW-1:0]     days;
  logic [e2c_pkg::MonthW-1:0]   mon;
  logic [6:0]                   cent;
  logic [8:0]                   quad;

  logic [50:0]                  prod_day;
  logic [26:0]                  prod_hour;
  logic [20:0]                  prod_min;
  logic [32:0]                  prod_wday;
  logic [e2c_pkg::QuoW-1:0]     quo_calc;
  logic [e2c_pkg::SecondsW-1:0] rem_full;
  logic                         leap;
  logic [8:0]                   ylen;
  logic [4:0]                   mlen;

  always_comb begin
    // Quotient phase: multiply the dividend by the reciprocal and keep the top bits
    prod_day  = {26'd0, acc[31:7]} * {25'd0, e2c_pkg::DayRecip};
    prod_hour = {14'd0, acc[16:4]} * {13'd0, e2c_pkg::HourRecip};
    prod_min  = {11'd0, acc[11:2]} * {10'd0, e2c_pkg::MinRecip};
    prod_wday = {17'd0, acc[15:0]} * {16'd0, e2c_pkg::WdayRecip};
    unique case (cmd.sel)
      e2c_pkg::DIV_DAY:  quo_calc = prod_day[50:35];
      e2c_pkg::DIV_HOUR: quo_calc = {10'd0, prod_hour[26:21]};
      e2c_pkg::DIV_MIN:  quo_calc = {9'd0, prod_min[20:14]};
      e2c_pkg::DIV_WDAY: quo_calc = {2'd0, prod_wday[32:19]};
      default:           quo_calc = '0;
    endcase
    // Remainder phase: drop quotient times divisor from the dividend
    rem_full = acc - ({16'd0, quo} * {15'd0, e2c_pkg::divisor_of(cmd.sel)});
    leap     = (year[1:0] == 2'b00) && ((cent != '0) || (quad == '0));
    ylen     = leap ? 9'd366 : 9'd365;
    mlen     = e2c_pkg::month_len(leap, mon);
    status.year_done  = (acc < {23'd0, ylen});
    status.month_done = (mon == e2c_pkg::LastMonth) || (acc < {27'd0, mlen});
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      e2c_pkg::OP_NONE: ;
      e2c_pkg::OP_LOAD: begin
        acc <= unix_seconds;
      end
      e2c_pkg::OP_QUO: begin
        quo <= quo_calc;
      end
      e2c_pkg::OP_REM: begin
        unique case (cmd.sel)
          e2c_pkg::DIV_DAY: begin
            days <= quo;
            acc  <= rem_full;
          end
          e2c_pkg::DIV_HOUR: begin
            hour <= quo[e2c_pkg::HourW-1:0];
            acc  <= rem_full;
          end
          e2c_pkg::DIV_MIN: begin
            minute <= quo[e2c_pkg::MinuteW-1:0];
            second <= rem_full[e2c_pkg::SecondW-1:0];
            acc    <= {16'd0, days} + e2c_pkg::WeekdayBias;
          end
          e2c_pkg::DIV_WDAY: begin
            weekday <= rem_full[e2c_pkg::WeekdayW-1:0];
            acc     <= {16'd0, days};
            year    <= e2c_pkg::EpochYear;
            cent    <= e2c_pkg::EpochCent;
            quad    <= e2c_pkg::EpochQuad;
            mon     <= '0;
          end
          default: ;
        endcase
      end
      e2c_pkg::OP_YEAR: begin
        acc  <= acc - {23'd0, ylen};
        year <= year + 1'b1;
        cent <= (cent == e2c_pkg::CentLast) ? '0 : cent + 1'b1;
        quad <= (quad == e2c_pkg::QuadLast) ? '0 : quad + 1'b1;
      end
      e2c_pkg::OP_MONTH: begin
        acc <= acc - {27'd0, mlen};
        mon <= mon + 1'b1;
      end
      default: ;
    endcase
  end

  assign month        = mon + 1'b1;
  assign day_of_month = acc[e2c_pkg::DayW-1:0] + 1'b1;

endmodule

/* hw/rtl/epoch_seconds_to_calendar.sv */
// Top level: Unix seconds to Gregorian calendar and clock fields.
// Depends on e2c_pkg, e2c_ctrl and e2c_datapath.
//
//  channel  | signals                                  | transfer
//  ---------+------------------------------------------+------------------------------
//  command  | start, busy, unix_seconds                | edge with start=1 and busy=0
//  result   | done, year, month, day_of_month, hour,   | edge ending the done cycle
//           | minute, second, weekday                  |
//
// Sequence: the transfer edge loads the time; then a quotient step (reciprocal multiply)
// and a remainder step (multiply and subtract) each for days, hour, minute/second and
// weekday, a year subtract per elapsed year plus a final check, a month subtract per
// elapsed month plus a final check, and a done state; busy stays high throughout.
// The year subtract loop dominates the latency.
// Reset: rst is synchronous; it returns the controller to idle with busy low.
// Stalls: busy stays high from transfer to the done cycle; results show only while
// done is high and the receiver takes them in that cycle.

module epoch_seconds_to_calendar (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [e2c_pkg::SecondsW-1:0]  unix_seconds,
  output logic                          busy,
  output logic                          done,
  output logic [e2c_pkg::YearW-1:0]     year,
  output logic [e2c_pkg::MonthW-1:0]    month,
  output logic [e2c_pkg::DayW-1:0]      day_of_month,
  output logic [e2c_pkg::HourW-1:0]     hour,
  output logic [e2c_pkg::MinuteW-1:0]   minute,
  output logic [e2c_pkg::SecondW-1:0]   second,
  output logic [e2c_pkg::WeekdayW-1:0]  weekday
);

  e2c_pkg::cmd_t    cmd;
  e2c_pkg::status_t status;

  // Sequence the passes; hold busy until the result is shown
  e2c_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Divide, then drop whole years and whole months from the day count
  e2c_datapath u_dp (
    .clk          (clk),
    .unix_seconds (unix_seconds),
    .cmd          (cmd),
    .status       (status),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .weekday      (weekday)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("controller did not return to idle after result");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobed while idle");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (month >= 4'd1 && month <= 4'd12 && day_of_month != 5'd0))
    else $error("month or day out of range");

  a_clock_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hour <= 5'd23 && weekday <= 3'd6 && minute <= 6'd59 && second <= 6'd59))
    else $error("clock field or weekday out of range");

endmodule

/* tb/sv/tb_epoch_seconds_to_calendar.sv */
// Testbench for epoch_seconds_to_calendar: directed and random epoch times, checked
// field by field against a calendar predictor built into this file.
// Depends on e2c_pkg and the epoch_seconds_to_calendar RTL.

module tb_epoch_seconds_to_calendar;

  localparam int RandomCount = 1450;
  localparam int StallLimit  = 4000;  // cycles without any transfer or result
  localparam int DrainCycles = 200;   // outlasts the longest conversion
  localparam int ReportMax   = 10;

  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned FirstYear   = 1970;
  localparam int unsigned DaysInMonth [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned February    = 1;   // zero-based
  localparam int unsigned December    = 11;  // zero-based

  typedef struct packed {
    logic [e2c_pkg::YearW-1:0]    year;
    logic [e2c_pkg::MonthW-1:0]   month;
    logic [e2c_pkg::DayW-1:0]     day_of_month;
    logic [e2c_pkg::HourW-1:0]    hour;
    logic [e2c_pkg::MinuteW-1:0]  minute;
    logic [e2c_pkg::SecondW-1:0]  second;
    logic [e2c_pkg::WeekdayW-1:0] weekday;
  } cal_fields_t;

  typedef struct packed {
    logic [e2c_pkg::SecondsW-1:0] secs;
    cal_fields_t                  cal;
  } dated_secs_t;

  logic                           clk          = 1'b0;
  logic                           rst          = 1'b1;
  logic                           start        = 1'b0;
  logic [e2c_pkg::SecondsW-1:0]   unix_seconds = '0;
  logic                           busy;
  logic                           done;
  logic [e2c_pkg::YearW-1:0]      year;
  logic [e2c_pkg::MonthW-1:0]     month;
  logic [e2c_pkg::DayW-1:0]       day_of_month;
  logic [e2c_pkg::HourW-1:0]      hour;
  logic [e2c_pkg::MinuteW-1:0]    minute;
  logic [e2c_pkg::SecondW-1:0]    second;
  logic [e2c_pkg::WeekdayW-1:0]   weekday;

  // Times waiting to be offered, and dates owed by the block in transfer order
  logic [e2c_pkg::SecondsW-1:0] pending_secs [$];
  dated_secs_t                  expected_dates [$];

  int n_items     = 0;
  int sent_count  = 0;
  int fail_count  = 0;
  int idle_cycles = 0;

  epoch_seconds_to_calendar dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .unix_seconds (unix_seconds),
    .busy         (busy),
    .done         (done),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .weekday      (weekday)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Gregorian rule: every 4th year, except centuries not divisible by 400
  function automatic bit gregorian_leap(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  // Predict the calendar date and clock time of a Unix second count
  function automatic cal_fields_t calendar_of(input logic [e2c_pkg::SecondsW-1:0] secs);
    int unsigned days;
    int unsigned sod;
    int unsigned yr;
    int unsigned mon;
    int unsigned mlen;
    int unsigned hr;
    int unsigned mi;
    int unsigned se;
    int unsigned wd;
    cal_fields_t c;
    days = secs / SecsPerDay;
    sod  = secs % SecsPerDay;
    hr   = sod / SecsPerHour;
    mi   = (sod % SecsPerHour) / SecsPerMin;
    se   = sod % SecsPerMin;
    wd   = (days + 4) % 7;  // day zero was a Thursday
    yr = FirstYear;
    while (days >= (gregorian_leap(yr) ? 366 : 365)) begin
      days -= gregorian_leap(yr) ? 366 : 365;
      yr++;
    end
    mon  = 0;
    mlen = DaysInMonth[0];
    while (mon < December && days >= mlen) begin
      days -= mlen;
      mon++;
      mlen = DaysInMonth[mon] + ((mon == February && gregorian_leap(yr)) ? 1 : 0);
    end
    mon  = mon + 1;
    days = days + 1;
    c.year         = yr[e2c_pkg::YearW-1:0];
    c.month        = mon[e2c_pkg::MonthW-1:0];
    c.day_of_month = days[e2c_pkg::DayW-1:0];
    c.hour         = hr[e2c_pkg::HourW-1:0];
    c.minute       = mi[e2c_pkg::MinuteW-1:0];
    c.second       = se[e2c_pkg::SecondW-1:0];
    c.weekday      = wd[e2c_pkg::WeekdayW-1:0];
    return c;
  endfunction

  // Count a failure; show the first few in full
  task automatic note_failure(input string what, input dated_secs_t want,
                              input cal_fields_t got);
    fail_count++;
    if (fail_count <= ReportMax) begin
      $display("%0t %s: secs=%0d expected %0d-%0d-%0d %0d:%0d:%0d wd%0d",
               $time, what, want.secs,
               want.cal.year, want.cal.month, want.cal.day_of_month,
               want.cal.hour, want.cal.minute, want.cal.second, want.cal.weekday);
      $display("    got %0d-%0d-%0d %0d:%0d:%0d wd%0d",
               got.year, got.month, got.day_of_month,
               got.hour, got.minute, got.second, got.weekday);
    end
  endtask

  // Driver: offer queued times on start. Once raised, start holds with the same
  // time until the block takes it. The sender idles 35 percent of cycles over
  // the first third of the items, 80 percent over the second, and never after.
  // Times offered while busy is high sit on the port until busy drops.
  always @(posedge clk) begin : drive
    logic                         nxt_start;
    logic [e2c_pkg::SecondsW-1:0] nxt_secs;
    int                           idle_pct;
    nxt_start = start;
    nxt_secs  = unix_seconds;
    if (rst) begin
      nxt_start = 1'b0;
    end else begin
      if (start && !busy) begin
        // Transfer at this edge: record the date the block now owes
        expected_dates.push_back('{secs: unix_seconds, cal: calendar_of(unix_seconds)});
        sent_count++;
        nxt_start = 1'b0;
      end
      if (!nxt_start && pending_secs.size() != 0) begin
        idle_pct = (sent_count < n_items / 3)     ? 35 :
                   (sent_count < 2 * n_items / 3) ? 80 : 0;
        if ($urandom_range(0, 99) >= idle_pct) begin
          nxt_start = 1'b1;
          nxt_secs  = pending_secs.pop_front();
        end
      end
    end
    // One nonblocking write per signal per edge, so start never glitches
    start        <= nxt_start;
    unix_seconds <= nxt_secs;
  end

  // Monitor: a result is valid only in the done cycle; take it at the edge that
  // ends that cycle and match it against the oldest owed date.
  always @(posedge clk) begin : check
    cal_fields_t got;
    dated_secs_t want;
    if (!rst && done) begin
      got = '{year: year, month: month, day_of_month: day_of_month, hour: hour,
              minute: minute, second: second, weekday: weekday};
      if (expected_dates.size() == 0) begin
        want = '0;
        note_failure("result with nothing outstanding", want, got);
      end else begin
        want = expected_dates.pop_front();
        if (want.cal !== got)
          note_failure("mismatch", want, got);
      end
    end
  end

  // Watchdog: any transfer or result resets the count; a hung block trips it
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [e2c_pkg::SecondsW-1:0] corner_secs [] = '{
      32'd0,            // the epoch itself, a Thursday
      32'd1,
      32'd59,           // last second of the first minute
      32'd60,
      32'd3599,         // last second of the first hour
      32'd3600,
      32'd86399,        // last second of the first day
      32'd86400,
      32'd31535999,     // 1970-12-31 23:59:59
      32'd31536000,     // 1971-01-01
      32'd68169600,     // 1972-02-29, first leap day
      32'd94694399,     // 1972-12-31 23:59:59, end of a leap year
      32'd946684799,    // 1999-12-31 23:59:59
      32'd951782400,    // 2000-02-29, leap century
      32'd951868800,    // 2000-03-01
      32'd2147483647,   // top of the signed range, 2038-01-19
      32'd2147483648,   // one past it
      32'd4102444799,   // 2099-12-31 23:59:59
      32'd4107456000,   // 2100-02-28, century without a leap day
      32'd4107542400,   // 2100-03-01
      32'hAAAA_AAAA,
      32'h5555_5555,
      32'd4294944000,   // start of the last day in range
      32'hFFFF_FFFF     // largest time, 2106-02-07 06:28:15
    };
    int          pick;
    int unsigned day_no;

    foreach (corner_secs[i])
      pending_secs.push_back(corner_secs[i]);

    // Random times: mostly uniform over the whole range, with some pinned to
    // day edges and some inside the first years where the loops are short
    for (int i = 0; i < RandomCount; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        pending_secs.push_back($urandom);
      end else if (pick < 8) begin
        day_no = $urandom_range(0, 49709);
        pending_secs.push_back(day_no * SecsPerDay + ($urandom_range(0, 1) ? 86399 : 0));
      end else begin
        pending_secs.push_back($urandom_range(0, 32'd200000000));
      end
    end
    n_items = pending_secs.size();

    // Hold reset at the start, then release it for good
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait for every time to be taken and every owed date to come back
    while (pending_secs.size() != 0 || start || expected_dates.size() != 0)
      @(posedge clk);
    // Let a late stray result show up before closing
    repeat (DrainCycles) @(posedge clk);

    fail_count += expected_dates.size();
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
